@@ src/axis_position_trust_tracker_macros.svh @@
// ----------------------------------------------------------------------------
// Position trust tracker assertion macros
// Concurrent assertion helpers; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef AXIS_POSITION_TRUST_TRACKER_MACROS_SVH
`define AXIS_POSITION_TRUST_TRACKER_MACROS_SVH

`ifndef SYNTHESIS

// property holds in the same cycle
`define APT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// property holds in the next cycle
`define APT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define APT_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define APT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

@@ src/apt_pkg.sv @@
// ----------------------------------------------------------------------------
// apt_pkg
// Shared types and constants of the axis position trust tracker.
// ----------------------------------------------------------------------------
package apt_pkg;

  // register widths and reset values
  localparam int MAX_POS_BITS     = 18;
  localparam int PPM_BITS         = 16;
  localparam int CFG_DATA_BITS    = 18;
  localparam int CFG_INDEX_BITS   = 1;
  localparam int POSITION_BITS_DEF = 18;
  localparam logic [MAX_POS_BITS-1:0] MAX_POSITION_RESET = 18'd136000;
  localparam logic [PPM_BITS-1:0]     PPM_RESET          = 16'd800;

  // field widths
  localparam int OP_BITS     = 3;
  localparam int STEP_BITS   = 16;
  localparam int RESTORE_BITS = 32;
  localparam int REASON_BITS = 3;
  localparam int PULSE_BITS  = 18;
  localparam int MM_BITS     = 22;
  localparam int IN_DATA_BITS  = 56;
  localparam int OUT_DATA_BITS = 48;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_POSITION  = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PULSES_PER_MM = 1'd1;

  // event codes
  localparam logic [OP_BITS-1:0] OP_HOME     = 3'd0;
  localparam logic [OP_BITS-1:0] OP_RESTORE  = 3'd1;
  localparam logic [OP_BITS-1:0] OP_UNTRUST  = 3'd2;
  localparam logic [OP_BITS-1:0] OP_MOVE     = 3'd3;
  localparam logic [OP_BITS-1:0] OP_SAFETY   = 3'd4;

  // untrusted reason codes
  typedef enum logic [REASON_BITS-1:0] {
    RSN_NONE      = 3'd0,
    RSN_NOT_HOMED = 3'd1,
    RSN_RANGE     = 3'd2,
    RSN_MOTOR     = 3'd3,
    RSN_LIMIT     = 3'd4,
    RSN_STALL     = 3'd5
  } reason_t;

  // status flags handed from the state unit to the top level
  typedef struct packed {
    logic    trusted;
    reason_t reason;
    logic    error;
    logic    restore_ok;
  } apt_status_t;

endpackage

@@ src/apt_state.sv @@
// ----------------------------------------------------------------------------
// apt_state
// Event decoder and trust state: position, trusted flag, reason, error latch.
// ----------------------------------------------------------------------------
module apt_state #(
  parameter int POSITION_BITS = apt_pkg::POSITION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic [apt_pkg::OP_BITS-1:0]        operation,
  input  logic                               move_down,
  input  logic [apt_pkg::STEP_BITS-1:0]      step_count,
  input  logic [apt_pkg::RESTORE_BITS-1:0]   restore_position,
  input  logic                               restore_trusted,
  input  logic [apt_pkg::REASON_BITS-1:0]    reason_in,
  input  logic                               motor_released,
  input  logic                               limit_mismatch,
  input  logic                               stall_active,
  input  logic [apt_pkg::MAX_POS_BITS-1:0]   max_position,
  output logic [POSITION_BITS-1:0]           position,
  output apt_pkg::apt_status_t               status
);
  import apt_pkg::*;

  localparam int LW = (POSITION_BITS > MAX_POS_BITS) ? POSITION_BITS : MAX_POS_BITS;
  localparam int NW = ((POSITION_BITS > STEP_BITS) ? POSITION_BITS : STEP_BITS) + 2;
  localparam logic [LW-1:0] POS_MASK = LW'((64'd1 << POSITION_BITS) - 64'd1);

  logic [POSITION_BITS-1:0] position_next;
  apt_status_t              status_next;
  logic [LW-1:0]            max_w;
  logic [LW-1:0]            lim;
  logic                     restore_out;
  logic [NW-1:0]            move_sum;
  logic                     move_out;
  reason_t                  req_reason;

  // range limit clipped to what the position register holds
  assign max_w = LW'(max_position);
  assign lim   = (max_w > POS_MASK) ? POS_MASK : max_w;

  // restore value out of range: negative or above the limit
  assign restore_out = restore_position[RESTORE_BITS-1] ||
                       (restore_position[RESTORE_BITS-2:0] > (RESTORE_BITS-1)'(lim));

  // move target and its range check
  assign move_sum = move_down ? (NW'(position) - NW'(step_count))
                              : (NW'(position) + NW'(step_count));
  assign move_out = move_sum[NW-1] || (move_sum > NW'(lim));

  // requested reason; none or unknown codes fall back to not homed
  always_comb begin
    if (reason_in == RSN_NONE || reason_in > RSN_STALL) begin
      req_reason = RSN_NOT_HOMED;
    end else begin
      req_reason = reason_t'(reason_in);
    end
  end

  // event decode
  always_comb begin
    position_next          = position;
    status_next            = status;
    status_next.restore_ok = 1'b0;
    unique case (operation)
      OP_HOME: begin
        position_next       = '0;
        status_next.trusted = 1'b1;
        status_next.reason  = RSN_NONE;
        status_next.error   = 1'b0;
      end
      OP_RESTORE: begin
        if (!restore_trusted) begin
          status_next.trusted = 1'b0;
          status_next.reason  = RSN_NOT_HOMED;
          status_next.error   = 1'b1;
        end else if (restore_out) begin
          position_next       = '0;
          status_next.trusted = 1'b0;
          status_next.reason  = RSN_RANGE;
          status_next.error   = 1'b1;
        end else begin
          position_next          = restore_position[POSITION_BITS-1:0];
          status_next.trusted    = 1'b1;
          status_next.reason     = RSN_NONE;
          status_next.error      = 1'b0;
          status_next.restore_ok = 1'b1;
        end
      end
      OP_UNTRUST: begin
        status_next.trusted = 1'b0;
        status_next.reason  = req_reason;
        status_next.error   = 1'b1;
      end
      OP_MOVE: begin
        if (status.trusted) begin
          if (move_out) begin
            status_next.trusted = 1'b0;
            status_next.reason  = RSN_RANGE;
            status_next.error   = 1'b1;
          end else begin
            position_next = move_sum[POSITION_BITS-1:0];
          end
        end
      end
      OP_SAFETY: begin
        // the last condition that holds sets the reason
        if (motor_released || limit_mismatch || stall_active) begin
          status_next.trusted = 1'b0;
          status_next.error   = 1'b1;
          if (stall_active) begin
            status_next.reason = RSN_STALL;
          end else if (limit_mismatch) begin
            status_next.reason = RSN_LIMIT;
          end else begin
            status_next.reason = RSN_MOTOR;
          end
        end
      end
      default: begin
        // unused codes only report status
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      position           <= '0;
      status.trusted     <= 1'b0;
      status.reason      <= RSN_NOT_HOMED;
      status.error       <= 1'b0;
      status.restore_ok  <= 1'b0;
    end else if (accept) begin
      position <= position_next;
      status   <= status_next;
    end
  end

endmodule

@@ src/apt_div.sv @@
// ----------------------------------------------------------------------------
// apt_div
// Bit-serial restoring divider, one quotient bit per cycle, result held
// until taken.
// ----------------------------------------------------------------------------
module apt_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [apt_pkg::MM_BITS-1:0]   dividend,
  input  logic [apt_pkg::PPM_BITS-1:0]  divisor,
  input  logic                          take,
  output logic                          idle,
  output logic                          done,
  output logic [apt_pkg::MM_BITS-1:0]   quotient
);
  import apt_pkg::*;

  localparam int CNT_BITS = $clog2(MM_BITS);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(MM_BITS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_HOLD
  } div_state_t;

  div_state_t           state;
  logic [PPM_BITS-1:0]  dvsr;
  logic [PPM_BITS-1:0]  rem;
  logic [MM_BITS-1:0]   shreg;
  logic [CNT_BITS-1:0]  cnt;
  logic                 zero_div;
  logic [PPM_BITS:0]    trial;
  logic [PPM_BITS:0]    trial_sub;
  logic                 fits;

  // one restoring step: bring in the next dividend bit, try to subtract
  assign trial     = {rem, shreg[MM_BITS-1]};
  assign trial_sub = trial - {1'b0, dvsr};
  assign fits      = (trial >= {1'b0, dvsr});

  assign idle     = (state == S_IDLE);
  assign done     = (state == S_HOLD);
  assign quotient = zero_div ? '0 : shreg;

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state    <= S_RUN;
            shreg    <= dividend;
            dvsr     <= divisor;
            zero_div <= (divisor == '0);
            rem      <= '0;
            cnt      <= CNT_LAST;
          end
        end
        S_RUN: begin
          rem   <= fits ? trial_sub[PPM_BITS-1:0] : trial[PPM_BITS-1:0];
          shreg <= {shreg[MM_BITS-2:0], fits};
          cnt   <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ src/axis_position_trust_tracker.sv @@
// ----------------------------------------------------------------------------
// axis_position_trust_tracker
// Stepper axis position tracker with trust flag, reason and error latch.
// ----------------------------------------------------------------------------
// Each input beat is one event (tuser selects it) and gives exactly one
// output beat with the updated position, the position in tenths of a mm,
// the trust flags and the auto-run permission. The state update is taken in
// the cycle of the input beat; the millimetre readout then comes from a
// bit-serial restoring divider that makes one quotient bit per cycle, and
// the next item is taken only once the divider is idle or hands off its
// result. A finished result waits in the divider until the output register
// is free, and the next item is accepted in the same cycle it moves there.
// max_position and pulses_per_mm must be written through cfg_we / cfg_index /
// cfg_data only while no item is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module axis_position_trust_tracker #(
  parameter int POSITION_BITS = apt_pkg::POSITION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [apt_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [apt_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  // event input
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [0] move_down, [16:1] step_count, [48:17] restore_position,
  // [49] restore_trusted, [52:50] reason_in, [53] motor_released,
  // [54] limit_mismatch, [55] stall_active
  input  logic [apt_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
  // [2:0] operation
  input  logic [apt_pkg::OP_BITS-1:0]         s_axis_tuser,
  // status output
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [17:0] position_pulses, [39:18] position_mm_x10, [40] is_trusted,
  // [43:41] untrusted_reason, [44] auto_run_allowed, [45] untrusted_error,
  // [46] restore_accepted, [47] zero
  output logic [apt_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata
);
  import apt_pkg::*;

  localparam int LW = (POSITION_BITS > MAX_POS_BITS) ? POSITION_BITS : MAX_POS_BITS;

  logic [MAX_POS_BITS-1:0]  max_position;
  logic [PPM_BITS-1:0]      pulses_per_mm;
  logic                     in_accept;
  logic                     start_pend;
  logic                     out_load;
  logic [POSITION_BITS-1:0] position;
  apt_status_t              status;
  logic [LW-1:0]            pos_w;
  logic [PULSE_BITS-1:0]    pos_pulses;
  logic [MM_BITS-1:0]       pos_x10;
  logic                     auto_run;
  logic                     div_idle;
  logic                     div_done;
  logic [MM_BITS-1:0]       mm_x10;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_position  <= MAX_POSITION_RESET;
      pulses_per_mm <= PPM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_POSITION:  max_position  <= cfg_data[MAX_POS_BITS-1:0];
        REG_PULSES_PER_MM: pulses_per_mm <= cfg_data[PPM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input handshake: free when the divider is idle or hands off its result, not while a start is pending
  assign out_load      = div_done && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !start_pend && (div_idle || out_load);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // divider start in the cycle after the state update
  always_ff @(posedge clk) begin
    if (rst) begin
      start_pend <= 1'b0;
    end else begin
      start_pend <= in_accept;
    end
  end

  apt_state #(
    .POSITION_BITS (POSITION_BITS)
  ) u_state (
    .clk              (clk),
    .rst              (rst),
    .accept           (in_accept),
    .operation        (s_axis_tuser),
    .move_down        (s_axis_tdata[0]),
    .step_count       (s_axis_tdata[16:1]),
    .restore_position (s_axis_tdata[48:17]),
    .restore_trusted  (s_axis_tdata[49]),
    .reason_in        (s_axis_tdata[52:50]),
    .motor_released   (s_axis_tdata[53]),
    .limit_mismatch   (s_axis_tdata[54]),
    .stall_active     (s_axis_tdata[55]),
    .max_position     (max_position),
    .position         (position),
    .status           (status)
  );

  // position never exceeds the 18-bit limit, so the part-select is exact
  assign pos_w      = LW'(position);
  assign pos_pulses = pos_w[PULSE_BITS-1:0];
  assign pos_x10    = (MM_BITS'(pos_pulses) << 3) + (MM_BITS'(pos_pulses) << 1);
  assign auto_run   = status.trusted && (pos_w <= LW'(max_position));

  apt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (start_pend),
    .dividend (pos_x10),
    .divisor  (pulses_per_mm),
    .take     (out_load),
    .idle     (div_idle),
    .done     (div_done),
    .quotient (mm_x10)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {1'b0, status.restore_ok, status.error, auto_run,
                       status.reason, status.trusted, mm_x10, pos_pulses};
    end
  end

`include "axis_position_trust_tracker_macros.svh"

  // one item in flight: no accept right after an accept
  `APT_ASSERT_NEXT(a_one_in_flight, clk, rst, in_accept, !s_axis_tready, "second beat taken while busy")
  // a trusted position has reason none and a clear error latch
  `APT_ASSERT_NOW(a_trust_consistent, clk, rst, m_axis_tvalid && m_axis_tdata[40], (m_axis_tdata[43:41] == RSN_NONE) && !m_axis_tdata[45], "trusted status inconsistent")
  // auto-run only when trusted
  `APT_ASSERT_NOW(a_auto_run_trusted, clk, rst, m_axis_tvalid && m_axis_tdata[44], m_axis_tdata[40], "auto-run without trust")

endmodule

@@ tb/sv/axis_position_trust_tracker_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// axis_position_trust_tracker_tb
// Self-checking bench for the axis position trust tracker. A scoreboard class
// keeps its own copy of position, trust flag, reason and error latch, and
// predicts the status beat that each accepted event produces. The run starts
// with directed events that cover travel ends, restore corner cases, reason
// mapping and the safety inputs. Random phases follow under several register
// settings, the extremes among them. Both stream sides stall at random,
// except in one steady phase.
// ----------------------------------------------------------------------------
module axis_position_trust_tracker_tb;
  import apt_pkg::*;

  localparam int IDLE_PCT    = 14;
  localparam int STALL_LIMIT = 2000;
  localparam int LATENCY     = 24;
  localparam longint MM_SCALE = 10;

  // reason and event codes the block does not define
  localparam logic [REASON_BITS-1:0] RSN_UNUSED_LO = 3'd6;
  localparam logic [REASON_BITS-1:0] RSN_UNUSED_HI = 3'd7;
  localparam logic [OP_BITS-1:0]     OP_UNUSED_FIRST = 3'd5;
  localparam logic [OP_BITS-1:0]     OP_UNUSED_LAST  = 3'd7;

  // input beat payload, lowest field last
  typedef struct packed {
    logic                    stall_active;
    logic                    limit_mismatch;
    logic                    motor_released;
    logic [REASON_BITS-1:0]  reason_in;
    logic                    restore_trusted;
    logic [RESTORE_BITS-1:0] restore_position;
    logic [STEP_BITS-1:0]    step_count;
    logic                    move_down;
  } event_data_t;

  // output beat payload, lowest field last
  typedef struct packed {
    logic                  spare;
    logic                  restore_ok;
    logic                  error;
    logic                  auto_run;
    reason_t               reason;
    logic                  trusted;
    logic [MM_BITS-1:0]    mm_x10;
    logic [PULSE_BITS-1:0] pulses;
  } status_beat_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the axis state and holds the expected status beats
  // --------------------------------------------------------------------------
  class trust_scoreboard;
    logic [MAX_POS_BITS-1:0] max_pos;
    logic [PPM_BITS-1:0]     ppm;
    logic [PULSE_BITS-1:0]   pos;
    logic                    trusted;
    reason_t                 reason;
    logic                    err;
    status_beat_t            pending[$];
    int                      mismatches;

    function new();
      max_pos    = MAX_POSITION_RESET;
      ppm        = PPM_RESET;
      pos        = '0;
      trusted    = 1'b0;
      reason     = RSN_NOT_HOMED;
      err        = 1'b0;
      mismatches = 0;
    endfunction

    function void set_register(input logic [CFG_INDEX_BITS-1:0] idx,
                               input logic [CFG_DATA_BITS-1:0] val);
      if (idx == REG_MAX_POSITION) max_pos = val[MAX_POS_BITS-1:0];
      else ppm = val[PPM_BITS-1:0];
    endfunction

    // no reason or an unknown one falls back to not homed
    function void distrust(input logic [REASON_BITS-1:0] code);
      if (code == RSN_NONE || code > RSN_STALL) code = RSN_NOT_HOMED;
      trusted = 1'b0;
      reason  = reason_t'(code);
      err     = 1'b1;
    endfunction

    function void trust_at(input logic [PULSE_BITS-1:0] p);
      pos     = p;
      trusted = 1'b1;
      reason  = RSN_NONE;
      err     = 1'b0;
    endfunction

    // apply one accepted event and queue the status it must report
    function void note_event(input logic [OP_BITS-1:0] op, input event_data_t d);
      longint       target;
      logic         restored;
      status_beat_t want;
      restored = 1'b0;
      case (op)
        OP_HOME: trust_at('0);
        OP_RESTORE: begin
          target = $signed(d.restore_position);
          if (!d.restore_trusted) begin
            distrust(RSN_NOT_HOMED);
          end else if (target < 0 || target > longint'(max_pos)) begin
            pos = '0;
            distrust(RSN_RANGE);
          end else begin
            trust_at(target[PULSE_BITS-1:0]);
            restored = 1'b1;
          end
        end
        OP_UNTRUST: distrust(d.reason_in);
        OP_MOVE: begin
          if (trusted) begin
            target = longint'(pos) + (d.move_down ? -longint'(d.step_count)
                                                  : longint'(d.step_count));
            if (target < 0 || target > longint'(max_pos)) distrust(RSN_RANGE);
            else pos = target[PULSE_BITS-1:0];
          end
        end
        OP_SAFETY: begin
          // later inputs override earlier ones
          if (d.motor_released) distrust(RSN_MOTOR);
          if (d.limit_mismatch) distrust(RSN_LIMIT);
          if (d.stall_active)   distrust(RSN_STALL);
        end
        default: ;
      endcase

      want            = '0;
      want.pulses     = pos;
      want.mm_x10     = (ppm == '0) ? '0
                        : MM_BITS'((longint'(pos) * MM_SCALE) / longint'(ppm));
      want.trusted    = trusted;
      want.reason     = reason;
      want.auto_run   = trusted && (pos <= max_pos);
      want.error      = err;
      want.restore_ok = restored;
      pending.push_back(want);
    endfunction

    function void check_status(input status_beat_t got);
      status_beat_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected status beat %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.pulses !== want.pulses || got.mm_x10 !== want.mm_x10 ||
          got.trusted !== want.trusted || got.reason !== want.reason ||
          got.auto_run !== want.auto_run || got.error !== want.error ||
          got.restore_ok !== want.restore_ok || got.spare !== want.spare) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("status mismatch: exp pos=%0d mm=%0d tr=%0b rsn=%0d auto=%0b err=%0b rst=%0b",
                   want.pulses, want.mm_x10, want.trusted, want.reason,
                   want.auto_run, want.error, want.restore_ok);
          $display("                 got pos=%0d mm=%0d tr=%0b rsn=%0d auto=%0b err=%0b rst=%0b pad=%0b",
                   got.pulses, got.mm_x10, got.trusted, got.reason,
                   got.auto_run, got.error, got.restore_ok, got.spare);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block I/O
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                      cfg_we    = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [IN_DATA_BITS-1:0]   s_axis_tdata  = '0;
  logic [OP_BITS-1:0]        s_axis_tuser  = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0]  m_axis_tdata;

  bit steady = 1'b0;
  int quiet_cycles = 0;
  trust_scoreboard tracker = new();

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  axis_position_trust_tracker uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // output side: random back-pressure, result check and watchdog
  always @(posedge clk) begin
    m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) tracker.check_status(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic event_data_t make_event(
      input logic down, input logic [STEP_BITS-1:0] steps,
      input logic [RESTORE_BITS-1:0] rpos, input logic rtr,
      input logic [REASON_BITS-1:0] rsn, input logic motor,
      input logic lim_mis, input logic stall);
    event_data_t d;
    d.move_down        = down;
    d.step_count       = steps;
    d.restore_position = rpos;
    d.restore_trusted  = rtr;
    d.reason_in        = rsn;
    d.motor_released   = motor;
    d.limit_mismatch   = lim_mis;
    d.stall_active     = stall;
    return d;
  endfunction

  // send one event beat; valid stays up when the next beat follows at once
  task automatic push_event(input logic [OP_BITS-1:0] op, input event_data_t d);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    tracker.note_event(op, d);
  endtask

  // stop sending and wait for every queued status beat
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    tracker.set_register(idx, val);
  endtask

  task automatic configure(input logic [MAX_POS_BITS-1:0] max_val,
                           input logic [PPM_BITS-1:0] ppm_val);
    write_reg(REG_MAX_POSITION, max_val);
    write_reg(REG_PULSES_PER_MM, CFG_DATA_BITS'(ppm_val));
    cfg_we <= 1'b0;
  endtask

  // random event, mostly moves while trusted so the position roams the travel
  task automatic make_random(output logic [OP_BITS-1:0] op, output event_data_t d);
    logic [63:0] noise;
    int pick, sub, lim, cur, span;
    noise = {$urandom, $urandom};
    d     = noise[IN_DATA_BITS-1:0];
    lim   = tracker.max_pos;
    cur   = tracker.pos;
    pick  = $urandom_range(99);
    sub   = $urandom_range(99);
    // re-home now and then so moves are not all ignored
    if (!tracker.trusted && pick >= 18 && pick < 75 && sub < 25) pick = 0;
    if (pick < 6) begin
      op = OP_HOME;
    end else if (pick < 18) begin
      op = OP_RESTORE;
      d.restore_trusted = (sub >= 70 && sub < 80) ? 1'b0 : 1'b1;
      if (sub < 55)      d.restore_position = $urandom_range(lim);
      else if (sub < 62) d.restore_position = lim;
      else if (sub < 66) d.restore_position = '0;
      else if (sub < 70) d.restore_position = lim + 1;
      // otherwise keep the raw value: mostly negative or far out of range
    end else if (pick < 23) begin
      op = OP_UNTRUST;
    end else if (pick < 75) begin
      op = OP_MOVE;
      if (sub < 70) begin
        d.step_count = STEP_BITS'($urandom_range(lim / 16 + 4));
      end else if (sub < 85) begin
        // land exactly on a travel end, or one step past it
        span = d.move_down ? cur : lim - cur;
        if (span < 0) span = 0;
        if (sub >= 78) span = span + 1;
        d.step_count = (span > 65535) ? 16'hFFFF : span[15:0];
      end
    end else if (pick < 93) begin
      op = OP_SAFETY;
      if (sub < 50) {d.stall_active, d.limit_mismatch, d.motor_released} = '0;
    end else begin
      op = OP_BITS'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
    end
  endtask

  // home, restore to the travel end, then random events
  task automatic run_phase(input int count);
    logic [OP_BITS-1:0] op;
    event_data_t        d;
    push_event(OP_HOME, make_event(1'b0, '0, '0, 1'b0, RSN_NONE, 1'b0, 1'b0, 1'b0));
    push_event(OP_RESTORE, make_event(1'b0, '0, RESTORE_BITS'(tracker.max_pos), 1'b1,
                                      RSN_NONE, 1'b0, 1'b0, 1'b0));
    repeat (count) begin
      make_random(op, d);
      push_event(op, d);
    end
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed events at reset settings (limit 136000, 800 pulses per mm)
    push_event(OP_MOVE, make_event(1'b0, 16'd5, '0, 1'b0, RSN_NONE, 1'b0, 1'b0, 1'b0));
    push_event(OP_HOME, make_event(1'b1, '1, '1, 1'b1, RSN_UNUSED_HI, 1'b1, 1'b1, 1'b1));
    push_event(OP_MOVE, make_event(1'b0, '1, '0, 1'b0, RSN_NONE, 1'b0, 1'b0, 1'b0));
    push_event(OP_MOVE, make_event(1'b0, '1, '0, 1'b0, RSN_NONE, 1'b0, 1'b0, 1'b0));
    // up to exactly the limit, then one step past it
    push_event(OP_MOVE, make_event(1'b0, 16'd4930, '0, 1'b0, RSN_NONE, 1'b0, 1'b0, 1'b0));
    push_event(OP_MOVE, make_event(1'b0, 16'd1, '0, 1'b0, RSN_NONE, 1'b0, 1'b0, 1'b0));
    // below zero from home
    push_event(OP_HOME, make_event(1'b0, '0, '0, 1'b0, RSN_NONE, 1'b0, 1'b0, 1'b0));
    push_event(OP_MOVE, make_event(1'b1, 16'd1, '0, 1'b0, RSN_NONE, 1'b0, 1'b0, 1'b0));
    // restore at the limit, then a full down move and a zero-step move
    push_event(OP_RESTORE, make_event(1'b0, '0, RESTORE_BITS'(MAX_POSITION_RESET), 1'b1,
                                      RSN_NONE, 1'b0, 1'b0, 1'b0));
    push_event(OP_MOVE, make_event(1'b1, '1, '0, 1'b0, RSN_NONE, 1'b0, 1'b0, 1'b0));
    push_event(OP_MOVE, make_event(1'b1, '0, '0, 1'b0, RSN_NONE, 1'b0, 1'b0, 1'b0));
    // restores out of range: just past the limit, -1, most negative, most positive
    push_event(OP_RESTORE, make_event(1'b0, '0, RESTORE_BITS'(MAX_POSITION_RESET) + 1,
                                      1'b1, RSN_NONE, 1'b0, 1'b0, 1'b0));
    push_event(OP_RESTORE, make_event(1'b0, '0, 32'hFFFF_FFFF, 1'b1, RSN_NONE,
                                      1'b0, 1'b0, 1'b0));
    push_event(OP_RESTORE, make_event(1'b0, '0, 32'h8000_0000, 1'b1, RSN_NONE,
                                      1'b0, 1'b0, 1'b0));
    push_event(OP_RESTORE, make_event(1'b0, '0, 32'h7FFF_FFFF, 1'b1, RSN_NONE,
                                      1'b0, 1'b0, 1'b0));
    // restore zero, restore saved as untrusted, restore mid travel
    push_event(OP_RESTORE, make_event(1'b0, '0, '0, 1'b1, RSN_NONE, 1'b0, 1'b0, 1'b0));
    push_event(OP_RESTORE, make_event(1'b0, '0, 32'd1234, 1'b0, RSN_NONE, 1'b0, 1'b0, 1'b0));
    push_event(OP_RESTORE, make_event(1'b0, '0, 32'd99999, 1'b1, RSN_NONE, 1'b0, 1'b0, 1'b0));
    // mark untrusted: no reason and an unknown reason map to not homed
    push_event(OP_UNTRUST, make_event(1'b0, '0, '0, 1'b0, RSN_NONE, 1'b0, 1'b0, 1'b0));
    push_event(OP_UNTRUST, make_event(1'b0, '0, '0, 1'b0, RSN_UNUSED_LO, 1'b0, 1'b0, 1'b0));
    push_event(OP_UNTRUST, make_event(1'b0, '0, '0, 1'b0, RSN_LIMIT, 1'b0, 1'b0, 1'b0));
    // safety checks: none holds, then the last input that holds wins
    push_event(OP_HOME, make_event(1'b0, '0, '0, 1'b0, RSN_NONE, 1'b0, 1'b0, 1'b0));
    push_event(OP_SAFETY, make_event(1'b0, '0, '0, 1'b0, RSN_NONE, 1'b0, 1'b0, 1'b0));
    push_event(OP_SAFETY, make_event(1'b0, '0, '0, 1'b0, RSN_NONE, 1'b1, 1'b1, 1'b0));
    push_event(OP_SAFETY, make_event(1'b0, '0, '0, 1'b0, RSN_NONE, 1'b1, 1'b1, 1'b1));
    push_event(OP_SAFETY, make_event(1'b0, '0, '0, 1'b0, RSN_NONE, 1'b1, 1'b0, 1'b0));
    // unknown event codes only report status
    push_event(OP_UNUSED_FIRST, make_event(1'b1, '1, '1, 1'b1, RSN_UNUSED_HI,
                                           1'b1, 1'b1, 1'b1));
    push_event(OP_UNUSED_LAST, make_event(1'b1, '1, '1, 1'b1, RSN_UNUSED_HI,
                                          1'b1, 1'b1, 1'b1));

    run_phase(100);

    // widest travel, finest readout, no stalls on either side
    configure(18'h3FFFF, 16'd1);
    steady = 1'b1;
    run_phase(120);
    steady = 1'b0;

    // tiny travel, coarsest divisor
    configure(18'd1, 16'hFFFF);
    run_phase(100);

    // zero limit and zero divisor
    configure('0, '0);
    run_phase(40);

    configure(MAX_POS_BITS'($urandom_range(262143, 1)), PPM_BITS'($urandom_range(65535, 1)));
    run_phase(110);

    configure(MAX_POSITION_RESET, PPM_RESET);
    run_phase(110);

    configure(MAX_POS_BITS'($urandom_range(300, 1)), PPM_BITS'($urandom_range(20, 1)));
    run_phase(90);

    repeat (2 * LATENCY) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/apt_pkg.sv
src/apt_state.sv
src/apt_div.sv
src/axis_position_trust_tracker.sv
tb/sv/axis_position_trust_tracker_tb.sv
